@@ hw/rtl/infix_expression_evaluator_assert.svh @@
// Assertion macros for the expression evaluator.
// Expects clk and rst_n in the including module's scope.
`ifndef INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define IEE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define IEE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/iee_pkg.sv @@
// Shared types, codes and helpers for the infix expression evaluator.
// No dependencies.
package iee_pkg;

    localparam int FIX_W = 48;

    localparam logic signed [FIX_W-1:0] FIX_MAX = {1'b0, {(FIX_W-1){1'b1}}};
    localparam logic signed [FIX_W-1:0] FIX_MIN = {1'b1, {(FIX_W-1){1'b0}}};

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_TIMES  = 8'h2A;
    localparam logic [7:0] CH_DIVIDE = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [1:0] {
        OP_PLUS   = 2'd0,
        OP_MINUS  = 2'd1,
        OP_TIMES  = 2'd2,
        OP_DIVIDE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_DIVZERO  = 2'd1,
        STS_EMPTY    = 2'd2,
        STS_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RES  = 4'b0010,
        S_MD   = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    // Command to the serial multiply/divide unit.
    typedef struct packed {
        logic start;
        logic is_div;
        logic neg;
    } md_cmd_t;

    // Response from the serial multiply/divide unit.
    typedef struct packed {
        logic done;
        logic ovf;
    } md_rsp_t;

    typedef struct packed {
        logic                    ovf;
        logic signed [FIX_W-1:0] value;
    } sat_t;

    // Keep the first error of an expression.
    function automatic status_t flag_err(status_t cur, status_t code);
        return (cur == STS_OK) ? code : cur;
    endfunction

    // Saturating 48-bit signed add.
    function automatic sat_t sat_add(logic signed [FIX_W-1:0] a,
                                     logic signed [FIX_W-1:0] b);
        logic signed [FIX_W:0] s;
        sat_t r;
        s       = {a[FIX_W-1], a} + {b[FIX_W-1], b};
        r.ovf   = s[FIX_W] != s[FIX_W-1];
        r.value = r.ovf ? (s[FIX_W] ? FIX_MIN : FIX_MAX) : s[FIX_W-1:0];
        return r;
    endfunction

endpackage

@@ hw/rtl/iee_muldiv.sv @@
// Bit-serial magnitude multiply (shift-add, saturating) and restoring divide.
// Depends on iee_pkg.
module iee_muldiv #(
    parameter int NUMBER_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  iee_pkg::md_cmd_t              cmd,
    input  logic [iee_pkg::FIX_W-1:0]     mag,
    input  logic [NUMBER_BITS-1:0]        number,
    output iee_pkg::md_rsp_t              rsp,
    output logic [iee_pkg::FIX_W-1:0]     res_mag
);

    localparam int FW    = iee_pkg::FIX_W;
    localparam int CNT_W = $clog2(FW);
    localparam logic [FW+1:0] BOUND_POS = {3'b000, {(FW-1){1'b1}}};
    localparam logic [FW+1:0] BOUND_NEG = {3'b001, {(FW-1){1'b0}}};

    logic             busy_reg;
    logic             done_reg;
    logic             div_reg;
    logic             neg_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [FW-1:0]          opd_reg;   // multiplicand, or dividend shifting into quotient
    logic [NUMBER_BITS-1:0] num_reg;   // multiplier (shifts out MSB first) or divisor
    logic [FW-1:0]          prod_reg;
    logic [NUMBER_BITS-1:0] rem_reg;

    logic [FW+1:0]        mul_sum;
    logic                 mul_over;
    logic [NUMBER_BITS:0] div_trial;
    logic [NUMBER_BITS:0] div_diff;
    logic                 div_fit;

    // Partial product never exceeds the bound, so 2*p + mag fits in FW+2 bits.
    assign mul_sum   = {1'b0, prod_reg, 1'b0}
                     + (num_reg[NUMBER_BITS-1] ? {2'b00, opd_reg} : '0);
    assign mul_over  = mul_sum > (neg_reg ? BOUND_NEG : BOUND_POS);
    assign div_trial = {rem_reg, opd_reg[FW-1]};
    assign div_diff  = div_trial - {1'b0, num_reg};
    assign div_fit   = div_trial >= {1'b0, num_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            div_reg  <= 1'b0;
            neg_reg  <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                div_reg  <= cmd.is_div;
                neg_reg  <= cmd.neg;
                ovf_reg  <= 1'b0;
                cnt_reg  <= cmd.is_div ? CNT_W'(FW - 1) : CNT_W'(NUMBER_BITS - 1);
            end
            else if (busy_reg) begin
                if (!div_reg && !ovf_reg && mul_over) begin
                    ovf_reg <= 1'b1;
                end
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.start) begin
            opd_reg  <= mag;
            num_reg  <= number;
            prod_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg) begin
            if (div_reg) begin
                rem_reg <= div_fit ? div_diff[NUMBER_BITS-1:0] : div_trial[NUMBER_BITS-1:0];
                opd_reg <= {opd_reg[FW-2:0], div_fit};
            end
            else begin
                if (!ovf_reg && !mul_over) begin
                    prod_reg <= mul_sum[FW-1:0];
                end
                num_reg <= num_reg << 1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign res_mag  = div_reg ? opd_reg : prod_reg;

endmodule

@@ hw/rtl/infix_expression_evaluator.sv @@
// Channel  | signals                                    | transaction
// ---------+--------------------------------------------+--------------------------------
// char     | char_valid, char_ready, char_code, last_char | one ASCII character in
// result   | result_valid, result_ready, result_value, status | one value per expression out
//
// A digit or an ignored character is taken in S_IDLE alone; + or - also passes through S_RES.
// * and / (but a divide by zero) also pass through S_RES and wait in S_MD on the bit-serial
// shift-add multiplier and the restoring divider (one bit per cycle).
// The last character of an expression also passes through S_RES and S_FIN to build the result.
// Reset (rst_n, asynchronous) clears the control state at once; there is no clearing pass.
// A result waiting on result_ready does not stop characters; only the next
// result does.
//
// Top level of the infix expression evaluator; uses iee_pkg and iee_muldiv,
// and assertion macros from infix_expression_evaluator_assert.svh.
`include "infix_expression_evaluator_assert.svh"

module infix_expression_evaluator #(
    parameter int FRAC_BITS   = 16,
    parameter int NUMBER_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               char_valid,
    output logic                               char_ready,
    input  logic [7:0]                         char_code,
    input  logic                               last_char,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic signed [iee_pkg::FIX_W-1:0]   result_value,
    output logic [1:0]                         status
);

    localparam int FW    = iee_pkg::FIX_W;
    localparam int ACC_W = NUMBER_BITS + 4;

    // Expression state
    iee_pkg::state_t         state_reg, state_next;
    logic signed [FW-1:0]    sum_reg, sum_next;          // running sum of finished terms
    logic signed [FW-1:0]    term_reg, term_next;        // current product/quotient term
    logic [NUMBER_BITS-1:0]  acc_reg, acc_next;          // decimal number being built
    logic                    seen_reg, seen_next;        // a digit came since last resolve
    iee_pkg::op_t            pend_reg, pend_next;        // operator waiting for its operand
    logic                    started_reg, started_next;  // a term is open
    iee_pkg::status_t        err_reg, err_next;

    // Character that triggered the current resolve
    logic                    last_reg, last_next;
    iee_pkg::op_t            nop_reg, nop_next;
    logic                    nopv_reg, nopv_next;

    // Output register
    logic                    rv_reg, rv_next;
    logic signed [FW-1:0]    rval_reg, rval_next;
    iee_pkg::status_t        rsts_reg, rsts_next;

    // Character decode
    logic                    is_digit;
    logic                    is_op;
    iee_pkg::op_t            char_op;
    logic [3:0]              digit;

    // Digit accumulation: acc * 10 + digit, saturating at all ones
    logic [ACC_W-1:0]        acc_x10;
    logic                    acc_ovf;

    // Operand conversion and term magnitude
    logic                    fix_ovf;
    logic signed [FW-1:0]    fixed_val;
    logic [FW-1:0]           term_mag;
    logic signed [FW-1:0]    md_signed;
    iee_pkg::sat_t           sum_sat;
    iee_pkg::status_t        err_tmp;

    iee_pkg::md_cmd_t        md_cmd;
    iee_pkg::md_rsp_t        md_rsp;
    logic [FW-1:0]           md_mag;
    logic                    finish;

    assign is_digit = (char_code >= iee_pkg::CH_ZERO) && (char_code <= iee_pkg::CH_NINE);
    assign is_op    = (char_code == iee_pkg::CH_PLUS) || (char_code == iee_pkg::CH_MINUS)
                   || (char_code == iee_pkg::CH_TIMES) || (char_code == iee_pkg::CH_DIVIDE);
    assign digit    = 4'(char_code - iee_pkg::CH_ZERO);

    always_comb begin
        unique case (char_code)
            iee_pkg::CH_MINUS:  char_op = iee_pkg::OP_MINUS;
            iee_pkg::CH_TIMES:  char_op = iee_pkg::OP_TIMES;
            iee_pkg::CH_DIVIDE: char_op = iee_pkg::OP_DIVIDE;
            default:            char_op = iee_pkg::OP_PLUS;
        endcase
    end

    assign acc_x10 = ACC_W'({acc_reg, 3'b000}) + ACC_W'({acc_reg, 1'b0}) + ACC_W'(digit);
    assign acc_ovf = |acc_x10[ACC_W-1:NUMBER_BITS];

    // Operand fits the fixed-point format only below 2^(47-FRAC_BITS).
    assign fix_ovf   = |(acc_reg >> (FW - 1 - FRAC_BITS));
    assign fixed_val = fix_ovf ? iee_pkg::FIX_MAX : (FW'(acc_reg) << FRAC_BITS);

    assign term_mag  = term_reg[FW-1] ? unsigned'(-term_reg) : unsigned'(term_reg);
    assign md_signed = term_reg[FW-1] ? -signed'(md_mag) : signed'(md_mag);
    assign sum_sat   = iee_pkg::sat_add(sum_reg, term_reg);

    iee_muldiv #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_muldiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (md_cmd),
        .mag     (term_mag),
        .number  (acc_reg),
        .rsp     (md_rsp),
        .res_mag (md_mag)
    );

    always_comb begin
        state_next   = state_reg;
        sum_next     = sum_reg;
        term_next    = term_reg;
        acc_next     = acc_reg;
        seen_next    = seen_reg;
        pend_next    = pend_reg;
        started_next = started_reg;
        err_next     = err_reg;
        last_next    = last_reg;
        nop_next     = nop_reg;
        nopv_next    = nopv_reg;
        rv_next      = rv_reg;
        rval_next    = rval_reg;
        rsts_next    = rsts_reg;
        md_cmd       = '0;
        finish       = 1'b0;
        // Empty operand is flagged before anything the operator itself flags.
        err_tmp      = seen_reg ? err_reg : iee_pkg::flag_err(err_reg, iee_pkg::STS_EMPTY);

        if (rv_reg && result_ready) begin
            rv_next = 1'b0;
        end

        unique case (state_reg)
            iee_pkg::S_IDLE: begin
                if (char_valid) begin
                    if (is_digit) begin
                        acc_next  = acc_ovf ? '1 : acc_x10[NUMBER_BITS-1:0];
                        seen_next = 1'b1;
                        if (acc_ovf) begin
                            err_next = iee_pkg::flag_err(err_reg, iee_pkg::STS_OVERFLOW);
                        end
                    end
                    last_next = last_char;
                    nop_next  = char_op;
                    nopv_next = is_op;
                    if (is_op || last_char) begin
                        state_next = iee_pkg::S_RES;
                    end
                end
            end

            iee_pkg::S_RES: begin
                unique case (pend_reg) inside
                    iee_pkg::OP_PLUS, iee_pkg::OP_MINUS: begin
                        if (started_reg) begin
                            sum_next = sum_sat.value;
                            if (sum_sat.ovf) begin
                                err_tmp = iee_pkg::flag_err(err_tmp, iee_pkg::STS_OVERFLOW);
                            end
                        end
                        if (fix_ovf) begin
                            err_tmp = iee_pkg::flag_err(err_tmp, iee_pkg::STS_OVERFLOW);
                        end
                        term_next    = (pend_reg == iee_pkg::OP_MINUS) ? -fixed_val : fixed_val;
                        started_next = 1'b1;
                        finish       = 1'b1;
                    end
                    iee_pkg::OP_TIMES: begin
                        md_cmd.start  = 1'b1;
                        md_cmd.is_div = 1'b0;
                        md_cmd.neg    = term_reg[FW-1];
                        state_next    = iee_pkg::S_MD;
                    end
                    default: begin
                        if (acc_reg == '0) begin
                            // Divide by zero saturates toward the term's sign.
                            err_tmp = iee_pkg::flag_err(err_tmp, iee_pkg::STS_DIVZERO);
                            if (term_reg[FW-1]) begin
                                term_next = iee_pkg::FIX_MIN;
                            end
                            else if (term_reg != '0) begin
                                term_next = iee_pkg::FIX_MAX;
                            end
                            finish = 1'b1;
                        end
                        else begin
                            md_cmd.start  = 1'b1;
                            md_cmd.is_div = 1'b1;
                            md_cmd.neg    = term_reg[FW-1];
                            state_next    = iee_pkg::S_MD;
                        end
                    end
                endcase
                err_next = err_tmp;
            end

            iee_pkg::S_MD: begin
                if (md_rsp.done) begin
                    if (md_rsp.ovf) begin
                        err_next  = iee_pkg::flag_err(err_reg, iee_pkg::STS_OVERFLOW);
                        term_next = term_reg[FW-1] ? iee_pkg::FIX_MIN : iee_pkg::FIX_MAX;
                    end
                    else begin
                        term_next = md_signed;
                    end
                    finish = 1'b1;
                end
            end

            iee_pkg::S_FIN: begin
                // Wait for the output register to free up, then emit and restart.
                if (!rv_reg || result_ready) begin
                    rv_next      = 1'b1;
                    rval_next    = sum_sat.value;
                    rsts_next    = sum_sat.ovf
                                 ? iee_pkg::flag_err(err_reg, iee_pkg::STS_OVERFLOW)
                                 : err_reg;
                    sum_next     = '0;
                    term_next    = '0;
                    acc_next     = '0;
                    seen_next    = 1'b0;
                    pend_next    = iee_pkg::OP_PLUS;
                    started_next = 1'b0;
                    err_next     = iee_pkg::STS_OK;
                    state_next   = iee_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = iee_pkg::S_IDLE;
            end
        endcase

        // Operand consumed: clear it and take up the new operator.
        if (finish) begin
            acc_next   = '0;
            seen_next  = 1'b0;
            if (nopv_reg) begin
                pend_next = nop_reg;
            end
            state_next = last_reg ? iee_pkg::S_FIN : iee_pkg::S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= iee_pkg::S_IDLE;
            sum_reg     <= '0;
            term_reg    <= '0;
            acc_reg     <= '0;
            seen_reg    <= 1'b0;
            pend_reg    <= iee_pkg::OP_PLUS;
            started_reg <= 1'b0;
            err_reg     <= iee_pkg::STS_OK;
            last_reg    <= 1'b0;
            nop_reg     <= iee_pkg::OP_PLUS;
            nopv_reg    <= 1'b0;
            rv_reg      <= 1'b0;
        end
        else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            term_reg    <= term_next;
            acc_reg     <= acc_next;
            seen_reg    <= seen_next;
            pend_reg    <= pend_next;
            started_reg <= started_next;
            err_reg     <= err_next;
            last_reg    <= last_next;
            nop_reg     <= nop_next;
            nopv_reg    <= nopv_next;
            rv_reg      <= rv_next;
        end
    end

    always_ff @(posedge clk) begin
        rval_reg <= rval_next;
        rsts_reg <= rsts_next;
    end

    assign char_ready   = state_reg == iee_pkg::S_IDLE;
    assign result_valid = rv_reg;
    assign result_value = rval_reg;
    assign status       = rsts_reg;

    `IEE_ASSERT_IMP(a_md_done_in_md, md_rsp.done, state_reg == iee_pkg::S_MD, "muldiv done outside wait state")
    `IEE_ASSERT_IMP(a_md_start_op, md_cmd.start, (pend_reg == iee_pkg::OP_TIMES) || (pend_reg == iee_pkg::OP_DIVIDE), "muldiv started for plus or minus")
    `IEE_ASSERT_NEXT(a_md_start_wait, md_cmd.start, state_reg == iee_pkg::S_MD, "no wait after muldiv start")
    `IEE_ASSERT_IMP(a_acc_seen, acc_reg != '0, seen_reg, "number built without a digit")
    `IEE_ASSERT_IMP(a_result_from_fin, $rose(rv_reg), $past(state_reg) == iee_pkg::S_FIN, "result loaded outside final state")

endmodule

@@ test/tb_infix_expression_evaluator.sv @@
// Self-checking testbench for infix_expression_evaluator: expressions are fed
// one character per transaction, and each result is checked against a predictor.
// Depends on iee_pkg and the evaluator RTL only.
module tb_infix_expression_evaluator;

    timeunit 1ns;
    timeprecision 1ps;

    import iee_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int NUMBER_BITS = 32;

    // Run length and end-of-test allowances
    localparam int RANDOM_ITEMS = 950;
    localparam int CYCLE_LIMIT  = 600000;   // far above the slowest legal run
    localparam int DRAIN_CYCLES = 120;      // room for a divide and the result, with margin

    localparam logic [63:0] NUMBER_CAP  = (64'd1 << NUMBER_BITS) - 64'd1;
    localparam logic [63:0] FIX_TOP     = 64'(FIX_MAX);
    localparam logic [63:0] OPERAND_CAP = FIX_TOP >> FRAC_BITS;

    // One character transaction waiting to be driven. hold makes the driver
    // wait until every outstanding result has come back before sending it.
    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       hold;
    } char_item_t;

    typedef struct packed {
        logic signed [FIX_W-1:0] value;
        status_t                 sts;
    } outcome_t;

    logic                    clk;
    logic                    rst_n        = 1'b0;
    logic                    char_valid   = 1'b0;
    logic                    char_ready;
    logic [7:0]              char_code    = 8'h00;
    logic                    last_char    = 1'b0;
    logic                    result_valid;
    logic                    result_ready = 1'b0;
    logic signed [FIX_W-1:0] result_value;
    logic [1:0]              status;

    char_item_t chars_q[$];         // characters not yet driven
    outcome_t   pending_results[$]; // predicted results, oldest first
    char_item_t next_char;
    outcome_t   want;

    bit hold_next    = 1'b0;
    int queued_cnt   = 0;   // every character queued, ignored ones too
    int key_cnt      = 0;   // characters the block acts on
    int accepted_cnt = 0;
    int fails        = 0;
    int cycles       = 0;
    logic quiet;

    // Predictor state, one expression in flight
    logic signed [FIX_W-1:0] sum_fx;
    logic signed [FIX_W-1:0] term_fx;
    logic [NUMBER_BITS-1:0]  number_acc;
    bit                      have_digit;
    op_t                     op_pending;
    bit                      term_live;
    status_t                 first_err;

    infix_expression_evaluator #(
        .FRAC_BITS   (FRAC_BITS),
        .NUMBER_BITS (NUMBER_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_code    (char_code),
        .last_char    (last_char),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_value (result_value),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic bit is_key_char(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
               c == CH_TIMES || c == CH_DIVIDE;
    endfunction

    // Keeps only the first error of the expression
    task automatic note_error(input status_t code);
        if (first_err == STS_OK)
            first_err = code;
    endtask

    function automatic logic signed [FIX_W-1:0] add_clamped(
        input  logic signed [FIX_W-1:0] a,
        input  logic signed [FIX_W-1:0] b,
        output bit                      ovf
    );
        logic signed [FIX_W:0] s;
        s   = a + b;
        ovf = 1'b1;
        if (s > FIX_MAX)
            return FIX_MAX;
        if (s < FIX_MIN)
            return FIX_MIN;
        ovf = 1'b0;
        return s[FIX_W-1:0];
    endfunction

    task automatic clear_expression();
        sum_fx     = '0;
        term_fx    = '0;
        number_acc = '0;
        have_digit = 1'b0;
        op_pending = OP_PLUS;
        term_live  = 1'b0;
        first_err  = STS_OK;
    endtask

    // Applies the pending operator with the number collected so far.
    task automatic resolve_operand();
        logic [63:0]        n;
        logic [63:0]        mag;
        logic [63:0]        lim;
        logic [63:0]        prod;
        logic [63:0]        fixed;
        logic signed [63:0] wide_term;
        bit                 neg;
        bit                 ovf;
        n         = 64'(number_acc);
        wide_term = term_fx;
        neg       = term_fx < 0;
        mag       = neg ? -wide_term : wide_term;
        if (!have_digit)
        begin
            note_error(STS_EMPTY);
            n = '0;
        end
        case (op_pending)
            OP_PLUS, OP_MINUS:
            begin
                if (term_live)
                begin
                    sum_fx = add_clamped(sum_fx, term_fx, ovf);
                    if (ovf)
                        note_error(STS_OVERFLOW);
                end
                if (n > OPERAND_CAP)
                begin
                    note_error(STS_OVERFLOW);
                    fixed = FIX_TOP;
                end
                else
                    fixed = n << FRAC_BITS;
                term_fx   = (op_pending == OP_MINUS) ? -fixed : fixed;
                term_live = 1'b1;
            end
            OP_TIMES:
            begin
                lim = neg ? FIX_TOP + 64'd1 : FIX_TOP;
                if (n != 0 && mag > lim / n)
                begin
                    note_error(STS_OVERFLOW);
                    term_fx = neg ? FIX_MIN : FIX_MAX;
                end
                else
                begin
                    prod    = mag * n;
                    term_fx = neg ? -prod : prod;
                end
            end
            default:
            begin
                // divide: truncates toward zero, divide by zero pins to the sign
                if (n == 0)
                begin
                    note_error(STS_DIVZERO);
                    if (term_fx > 0)
                        term_fx = FIX_MAX;
                    else if (term_fx < 0)
                        term_fx = FIX_MIN;
                end
                else
                begin
                    prod    = mag / n;
                    term_fx = neg ? -prod : prod;
                end
            end
        endcase
        number_acc = '0;
        have_digit = 1'b0;
    endtask

    // One accepted character; queues the expected result on the last one.
    task automatic eval_char(input logic [7:0] c, input logic last);
        logic [63:0]             grown;
        logic signed [FIX_W-1:0] total;
        bit                      ovf;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            grown = 64'(number_acc) * 64'd10 + 64'(c - CH_ZERO);
            if (grown > NUMBER_CAP)
            begin
                note_error(STS_OVERFLOW);
                grown = NUMBER_CAP;
            end
            number_acc = grown[NUMBER_BITS-1:0];
            have_digit = 1'b1;
        end
        if (is_key_char(c) && !(c >= CH_ZERO && c <= CH_NINE) || last)
        begin
            resolve_operand();
            case (c)
                CH_PLUS:   op_pending = OP_PLUS;
                CH_MINUS:  op_pending = OP_MINUS;
                CH_TIMES:  op_pending = OP_TIMES;
                CH_DIVIDE: op_pending = OP_DIVIDE;
                default:   ;
            endcase
        end
        if (last)
        begin
            total = add_clamped(sum_fx, term_fx, ovf);
            if (ovf)
                note_error(STS_OVERFLOW);
            pending_results.push_back('{value: total, sts: first_err});
            clear_expression();
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    task automatic push_char(input logic [7:0] c, input logic last);
        chars_q.push_back('{code: c, last: last, hold: hold_next});
        hold_next  = 1'b0;
        queued_cnt = queued_cnt + 1;
        if (is_key_char(c) || last)
            key_cnt = key_cnt + 1;
    endtask

    task automatic push_text(input string s, input logic last_on_end);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], last_on_end && i == s.len() - 1);
    endtask

    task automatic push_noise(input logic last);
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (is_key_char(c));
        push_char(c, last);
    endtask

    function automatic logic [7:0] pick_op();
        case ($urandom_range(3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_TIMES;
            default: return CH_DIVIDE;
        endcase
    endfunction

    // Mostly short numbers; now and then long enough to saturate
    task automatic push_operand(input logic last);
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 55)
            len = 1;
        else if (r < 80)
            len = $urandom_range(2, 3);
        else if (r < 92)
            len = $urandom_range(4, 5);
        else if (r < 97)
            len = $urandom_range(6, 9);
        else
            len = $urandom_range(10, 11);
        for (int j = 0; j < len; j++)
            push_char(CH_ZERO + 8'($urandom_range(9)), last && j == len - 1);
    endtask

    // ------------------------------------------------------------------
    // Idling: about 13 times in 100 on each side, except in quiet windows
    // ------------------------------------------------------------------

    assign quiet = (cycles % 8192) < 1600;

    function automatic bit idle_now();
        return !quiet && ($urandom_range(99) < 13);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: predicts on each accepted character, then presents the next
    // one. Valid is assigned once per edge, so it never glitches low.
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_code  <= 8'h00;
            last_char  <= 1'b0;
        end
        else
        begin
            if (char_valid && char_ready)
            begin
                eval_char(char_code, last_char);
                accepted_cnt = accepted_cnt + 1;
            end
            if (!char_valid || char_ready)
            begin
                if (chars_q.size() != 0 && !idle_now() &&
                    !(chars_q[0].hold && pending_results.size() != 0))
                begin
                    next_char = chars_q.pop_front();
                    char_code  <= next_char.code;
                    last_char  <= next_char.last;
                    char_valid <= 1'b1;
                end
                else
                    char_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= !idle_now();
    end

    // ------------------------------------------------------------------
    // Monitor: each accepted result against the oldest prediction
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got value %0d status %0d",
                         $time, result_value, status);
                fails = fails + 1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_value !== want.value)
                begin
                    $display("%0t: result_value expected %0d got %0d",
                             $time, want.value, result_value);
                    fails = fails + 1;
                end
                if (status !== want.sts)
                begin
                    $display("%0t: status expected %0d got %0d", $time, want.sts, status);
                    fails = fails + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: fill the character queue, release reset, wait for drain
    // ------------------------------------------------------------------

    initial
    begin
        int  kind;
        int  nterms;
        int  len;
        int  r;
        bit  held_mid;
        held_mid = 1'b0;
        clear_expression();

        // Directed part
        push_text("*", 1'b1);               // empty operand, operator as last char
        push_char("9", 1'b0);               // positive term over zero, 0xFF ignored
        push_char(8'hFF, 1'b0);
        push_text("/0", 1'b1);
        push_text("0/0", 1'b1);             // zero term over zero stays zero
        push_text("-1/0", 1'b1);            // empty lead operand, negative over zero
        push_text("1+1/3", 1'b0);           // quotient truncated, ends on ignored 0x00
        push_char(8'h00, 1'b1);
        push_text("9*999999999", 1'b1);     // product overflow

        // Random part; first expression waits for the directed results
        hold_next = 1'b1;
        while (key_cnt < RANDOM_ITEMS)
        begin
            if (!held_mid && key_cnt >= RANDOM_ITEMS / 2)
            begin
                hold_next = 1'b1;
                held_mid  = 1'b1;
            end
            kind = $urandom_range(99);
            if (kind < 80)
            begin
                // well-formed: operand (op operand)*, noise sprinkled in
                nterms = ($urandom_range(3) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
                for (int k = 0; k < nterms; k++)
                begin
                    if (k > 0)
                    begin
                        if ($urandom_range(19) == 0)
                            push_noise(1'b0);
                        push_char(pick_op(), 1'b0);
                    end
                    push_operand(k == nterms - 1);
                end
            end
            else if (kind < 88)
            begin
                // operands near the top of the format, to push the sum over
                nterms = $urandom_range(2, 3);
                for (int k = 0; k < nterms; k++)
                begin
                    if (k > 0)
                        push_char($urandom_range(1) ? CH_PLUS : CH_MINUS, 1'b0);
                    push_text($sformatf("%0d", $urandom_range(2147483647, 1500000000)),
                              k == nterms - 1);
                end
            end
            else
            begin
                // broken sequences: stray operators, empty operands, noise at the end
                len = $urandom_range(1, 8);
                for (int j = 0; j < len; j++)
                begin
                    r = $urandom_range(9);
                    if (r < 4)
                        push_char(CH_ZERO + 8'($urandom_range(9)), j == len - 1);
                    else if (r < 7)
                        push_char(pick_op(), j == len - 1);
                    else
                        push_noise(j == len - 1);
                end
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_cnt != queued_cnt || pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
